FILE: sv/c8i_pkg.sv
// Shared constants, codes and font table of the CHIP-8 interpreter core.
package c8i_pkg;

	localparam int MEM_AW = 12;

	localparam logic [2:0] ACT_EXEC = 3'd0;
	localparam logic [2:0] ACT_TICK = 3'd1;
	localparam logic [2:0] ACT_LOAD = 3'd2;
	localparam logic [2:0] ACT_KEYS = 3'd3;
	localparam logic [2:0] ACT_ROW  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_STK  = 2'd3;

	localparam logic [1:0] VAR_ORIG  = 2'd0;
	localparam logic [1:0] VAR_LATER = 2'd1;
	localparam logic [1:0] VAR_EXT   = 2'd2;
	localparam logic [1:0] VAR_ADDF  = 2'd3;

	localparam logic [11:0] FONT_BASE    = 12'd80;
	localparam logic [11:0] FONT_BYTES   = 12'd80;
	localparam logic [11:0] PROGRAM_BASE = 12'd512;

	localparam logic [7:0] FONT [80] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] init_byte(input logic [11:0] a);
		logic [11:0] k;
		k = a - FONT_BASE;
		if (a == 12'd0) return 8'h10;
		if (a >= FONT_BASE && k < FONT_BYTES) return FONT[k[6:0]];
		return 8'h00;
	endfunction

endpackage

FILE: sv/c8i_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module c8i_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/chip8_interpreter_core.sv
// CHIP-8 interpreter core: sequencer around program memory, display, register file and stack.
// One item at a time. After reset a clearing pass loads the font and clears the display
// and registers; no item is taken until it ends. An execute item fetches two bytes, reads
// VX, VY and V0 and executes, then adds a flag write, the BCD digit writes for FX33, a read
// and a write per row for DXYN and per register for FX55/FX65, and a pass over the display
// rows for 00E0; each memory has a single read port. A result waits in an output register
// while the next item is taken. Configuration writes are always ready.
module chip8_interpreter_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_data,
	input  logic [15:0] key_mask,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  row_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] program_counter_out,
	output logic        sound_active,
	output logic [63:0] row_pixels,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  machine_variant
);

	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_ROW, S_F1, S_F2, S_F3, S_F4, S_F5, S_EX, S_WF, S_CLS, S_RET,
		S_D0, S_D1, S_B1, S_B2, S_S0, S_S1, S_L0, S_L1, S_OUT
	} state_t;

	state_t state_q;
	logic [11:0] cnt_q, pc_q;
	logic [15:0] i_q, keys_q, rw_q;
	logic [4:0]  sl_q;
	logic [7:0]  dt_q, st_q, hi_q, vx_q, vy_q, v0_q, rnd_q;
	logic [15:0] op_q;
	logic [1:0]  halt_q, var_q;
	logic        wait_q, flag_q;
	logic [3:0]  bt_q, bo_q;
	logic [63:0] row_q;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [11:0] pc_out_q;
	logic        snd_q;
	logic [63:0] row_out_q;

	logic        mem_we;
	logic [11:0] mem_wa, mem_ra;
	logic [7:0]  mem_wd, mem_rd;
	logic        scr_we;
	logic [4:0]  scr_wa, scr_ra;
	logic [63:0] scr_wd, scr_rd;
	logic        vrf_we;
	logic [3:0]  vrf_wa, vrf_ra;
	logic [7:0]  vrf_wd, vrf_rd;
	logic          stk_we;
	logic [SW-1:0] stk_wa, stk_ra;
	logic [11:0]   stk_wd, stk_rd;

	logic [7:0]  alu_res, src, rem;
	logic [8:0]  sum9;
	logic        alu_flg, alu_wx, alu_wf, alu_bad, kw_done, key_on;
	logic [15:0] kw_up;
	logic [1:0]  hund;
	logic [14:0] tmul;
	logic [3:0]  tens, ones;
	logic [63:0] bits;
	logic [4:0]  drow;
	logic [11:0] nnn;
	logic [7:0]  nn;
	logic [3:0]  xr, nr;
	logic [7:0]  font_t;

	function automatic logic [3:0] low_bit(input logic [15:0] m);
		logic [3:0] k;
		k = 4'd0;
		for (int j = 15; j >= 0; j--) begin
			if (m[j]) k = 4'(j);
		end
		return k;
	endfunction

	c8i_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd), .raddr(mem_ra), .rdata(mem_rd));
	c8i_ram #(.WIDTH(64), .DEPTH(32)) u_scr (
		.clk(clk), .we(scr_we), .waddr(scr_wa), .wdata(scr_wd), .raddr(scr_ra), .rdata(scr_rd));
	c8i_ram #(.WIDTH(8), .DEPTH(16)) u_vrf (
		.clk(clk), .we(vrf_we), .waddr(vrf_wa), .wdata(vrf_wd), .raddr(vrf_ra), .rdata(vrf_rd));
	c8i_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

	assign nnn = op_q[11:0];
	assign nn  = op_q[7:0];
	assign xr  = op_q[11:8];
	assign nr  = op_q[3:0];
	assign bits = {mem_rd, 56'd0} >> vx_q[5:0];
	assign drow = vy_q[4:0] + cnt_q[4:0];
	assign key_on = keys_q[vx_q[3:0]];
	assign font_t = (var_q == c8i_pkg::VAR_ORIG) ? {4'd0, vx_q[3:0]} : vx_q;

	always_comb begin
		src  = (var_q == c8i_pkg::VAR_ORIG) ? vy_q : vx_q;
		sum9 = {1'b0, vx_q} + {1'b0, vy_q};
		kw_up = rw_q & ~keys_q;
		kw_done = 1'b0;
		alu_res = 8'd0;
		alu_flg = 1'b0;
		alu_wx  = 1'b0;
		alu_wf  = 1'b0;
		alu_bad = 1'b0;
		unique case (op_q[15:12])
			4'h6: begin
				alu_wx = 1'b1;
				alu_res = nn;
			end
			4'h7: begin
				alu_wx = 1'b1;
				alu_res = vx_q + nn;
			end
			4'hC: begin
				alu_wx = 1'b1;
				alu_res = rnd_q & nn;
			end
			4'h8: begin
				alu_wx = 1'b1;
				alu_wf = 1'b1;
				unique case (nr)
					4'h0: begin
						alu_res = vy_q;
						alu_wf = 1'b0;
					end
					4'h1: begin
						alu_res = vx_q | vy_q;
						alu_wf = (var_q == c8i_pkg::VAR_ORIG);
					end
					4'h2: begin
						alu_res = vx_q & vy_q;
						alu_wf = (var_q == c8i_pkg::VAR_ORIG);
					end
					4'h3: begin
						alu_res = vx_q ^ vy_q;
						alu_wf = (var_q == c8i_pkg::VAR_ORIG);
					end
					4'h4: begin
						alu_res = sum9[7:0];
						alu_flg = sum9[8];
					end
					4'h5: begin
						alu_res = vx_q - vy_q;
						alu_flg = (vx_q >= vy_q);
					end
					4'h6: begin
						alu_res = src >> 1;
						alu_flg = src[0];
					end
					4'h7: begin
						alu_res = vy_q - vx_q;
						alu_flg = (vy_q >= vx_q);
					end
					4'hE: begin
						alu_res = src << 1;
						alu_flg = src[7];
					end
					default: begin
						alu_wx = 1'b0;
						alu_wf = 1'b0;
						alu_bad = 1'b1;
					end
				endcase
			end
			4'hF: begin
				unique case (nn)
					8'h07: begin
						alu_wx = 1'b1;
						alu_res = dt_q;
					end
					8'h0A: begin
						if (var_q == c8i_pkg::VAR_ORIG) begin
							kw_done = (rw_q != 16'd0) && (kw_up != 16'd0);
							alu_res = {4'd0, low_bit(kw_up)};
						end else begin
							kw_done = (keys_q != 16'd0);
							alu_res = {4'd0, low_bit(keys_q)};
						end
						alu_wx = kw_done;
					end
					8'h1E: begin
						alu_wf = (var_q == c8i_pkg::VAR_ADDF);
						alu_flg = (i_q < 16'h0FFF) &&
							(({1'b0, i_q} + {9'd0, vx_q}) >= 17'h01000);
					end
					default: alu_bad = 1'b0;
				endcase
			end
			default: alu_bad = 1'b0;
		endcase
	end

	always_comb begin
		hund = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
		rem  = vx_q - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
		tmul = 15'(rem) * 15'd205;
		tens = 4'(tmul >> 11);
		ones = 4'(rem - 8'(tens) * 8'd10);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = 12'd0;
		mem_wd = 8'd0;
		mem_ra = 12'd0;
		scr_we = 1'b0;
		scr_wa = 5'd0;
		scr_wd = 64'd0;
		scr_ra = 5'd0;
		vrf_we = 1'b0;
		vrf_wa = 4'd0;
		vrf_wd = 8'd0;
		vrf_ra = 4'd0;
		stk_we = 1'b0;
		stk_wa = '0;
		stk_wd = pc_q;
		stk_ra = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = c8i_pkg::init_byte(cnt_q);
				scr_we = (cnt_q[11:5] == 7'd0);
				scr_wa = cnt_q[4:0];
				vrf_we = (cnt_q[11:4] == 8'd0);
				vrf_wa = cnt_q[3:0];
			end
			S_IDLE: begin
				if (in_valid) begin
					mem_ra = pc_q;
					scr_ra = row_select;
					if (action == c8i_pkg::ACT_LOAD) begin
						mem_we = 1'b1;
						mem_wa = load_address;
						mem_wd = load_data;
					end
				end
			end
			S_F1: mem_ra = pc_q + 12'd1;
			S_F2: vrf_ra = hi_q[3:0];
			S_F3: vrf_ra = op_q[7:4];
			S_F4: vrf_ra = 4'd0;
			S_EX: begin
				vrf_we = alu_wx;
				vrf_wa = xr;
				vrf_wd = alu_res;
				stk_ra = SW'(sl_q - 5'd1);
				stk_wa = SW'(sl_q);
				stk_we = (op_q[15:12] == 4'h2) && (sl_q < 5'(STACK_DEPTH));
				if (op_q[15:12] == 4'hF && nn == 8'h33) begin
					mem_we = 1'b1;
					mem_wa = i_q[11:0];
					mem_wd = {6'd0, hund};
				end
			end
			S_WF: begin
				vrf_we = 1'b1;
				vrf_wa = 4'hF;
				vrf_wd = {7'd0, flag_q};
			end
			S_CLS: begin
				scr_we = 1'b1;
				scr_wa = cnt_q[4:0];
			end
			S_D0: begin
				mem_ra = i_q[11:0] + 12'(cnt_q[3:0]);
				scr_ra = drow;
			end
			S_D1: begin
				scr_we = 1'b1;
				scr_wa = drow;
				scr_wd = scr_rd ^ bits;
			end
			S_B1: begin
				mem_we = 1'b1;
				mem_wa = i_q[11:0] + 12'd1;
				mem_wd = {4'd0, bt_q};
			end
			S_B2: begin
				mem_we = 1'b1;
				mem_wa = i_q[11:0] + 12'd2;
				mem_wd = {4'd0, bo_q};
			end
			S_S0: vrf_ra = cnt_q[3:0];
			S_S1: begin
				mem_we = 1'b1;
				mem_wa = i_q[11:0] + 12'(cnt_q[3:0]);
				mem_wd = vrf_rd;
			end
			S_L0: mem_ra = i_q[11:0] + 12'(cnt_q[3:0]);
			S_L1: begin
				vrf_we = 1'b1;
				vrf_wa = cnt_q[3:0];
				vrf_wd = mem_rd;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= 12'd0;
			pc_q <= 12'd0;
			i_q <= 16'd0;
			sl_q <= 5'd0;
			dt_q <= 8'd0;
			st_q <= 8'd0;
			keys_q <= 16'd0;
			rw_q <= 16'd0;
			halt_q <= c8i_pkg::ST_OK;
			var_q <= c8i_pkg::VAR_EXT;
			wait_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				var_q <= machine_variant;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q == 12'hFFF) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						wait_q <= 1'b0;
						row_q <= 64'd0;
						rnd_q <= random_byte;
						state_q <= S_OUT;
						case (action)
							c8i_pkg::ACT_EXEC: begin
								if (halt_q == c8i_pkg::ST_OK) state_q <= S_F1;
							end
							c8i_pkg::ACT_TICK: begin
								if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
								if (st_q != 8'd0) st_q <= st_q - 8'd1;
							end
							c8i_pkg::ACT_LOAD: pc_q <= c8i_pkg::PROGRAM_BASE;
							c8i_pkg::ACT_KEYS: keys_q <= key_mask;
							c8i_pkg::ACT_ROW: state_q <= S_ROW;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ROW: begin
					row_q <= scr_rd;
					state_q <= S_OUT;
				end
				S_F1: begin
					hi_q <= mem_rd;
					state_q <= S_F2;
				end
				S_F2: begin
					op_q <= {hi_q, mem_rd};
					pc_q <= pc_q + 12'd2;
					state_q <= S_F3;
				end
				S_F3: begin
					vx_q <= vrf_rd;
					state_q <= S_F4;
				end
				S_F4: begin
					vy_q <= vrf_rd;
					state_q <= S_F5;
				end
				S_F5: begin
					v0_q <= vrf_rd;
					state_q <= S_EX;
				end
				S_EX: begin
					cnt_q <= 12'd0;
					flag_q <= alu_flg;
					state_q <= alu_wf ? S_WF : S_OUT;
					unique case (op_q[15:12])
						4'h0: begin
							if (nnn == 12'h0E0) begin
								state_q <= S_CLS;
							end else if (nnn == 12'h0EE) begin
								if (sl_q == 5'd0) begin
									halt_q <= c8i_pkg::ST_STK;
								end else begin
									sl_q <= sl_q - 5'd1;
									state_q <= S_RET;
								end
							end else begin
								halt_q <= c8i_pkg::ST_BAD;
							end
						end
						4'h1: pc_q <= nnn;
						4'h2: begin
							if (sl_q >= 5'(STACK_DEPTH)) begin
								halt_q <= c8i_pkg::ST_STK;
							end else begin
								sl_q <= sl_q + 5'd1;
								pc_q <= nnn;
							end
						end
						4'h3: if (vx_q == nn) pc_q <= pc_q + 12'd2;
						4'h4: if (vx_q != nn) pc_q <= pc_q + 12'd2;
						4'h5: if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
						4'h9: if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
						4'h8: if (alu_bad) halt_q <= c8i_pkg::ST_BAD;
						4'hA: i_q <= {4'd0, nnn};
						4'hB: begin
							if (var_q == c8i_pkg::VAR_LATER || var_q == c8i_pkg::VAR_EXT) begin
								pc_q <= nnn + {4'd0, vx_q};
							end else begin
								pc_q <= nnn + {4'd0, v0_q};
							end
						end
						4'hD: begin
							flag_q <= 1'b0;
							state_q <= (nr == 4'd0) ? S_WF : S_D0;
						end
						4'hE: begin
							if (nn == 8'h9E) begin
								if (key_on) pc_q <= pc_q + 12'd2;
							end else if (nn == 8'hA1) begin
								if (!key_on) pc_q <= pc_q + 12'd2;
							end else begin
								halt_q <= c8i_pkg::ST_BAD;
							end
						end
						4'hF: begin
							case (nn)
								8'h07: state_q <= S_OUT;
								8'h0A: begin
									if (!kw_done) begin
										pc_q <= pc_q - 12'd2;
										wait_q <= 1'b1;
										if (var_q == c8i_pkg::VAR_ORIG) rw_q <= rw_q | keys_q;
									end else if (var_q == c8i_pkg::VAR_ORIG) begin
										rw_q <= 16'd0;
									end
								end
								8'h15: dt_q <= vx_q;
								8'h18: st_q <= vx_q;
								8'h1E: i_q <= i_q + {8'd0, vx_q};
								8'h29: i_q <= {4'd0, c8i_pkg::FONT_BASE} +
									{6'd0, font_t, 2'd0} + {8'd0, font_t};
								8'h33: begin
									bt_q <= tens;
									bo_q <= ones;
									state_q <= S_B1;
								end
								8'h55: state_q <= S_S0;
								8'h65: state_q <= S_L0;
								default: halt_q <= c8i_pkg::ST_BAD;
							endcase
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_WF: state_q <= S_OUT;
				S_CLS: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q[4:0] == 5'd31) state_q <= S_OUT;
				end
				S_RET: begin
					pc_q <= stk_rd;
					state_q <= S_OUT;
				end
				S_D0: state_q <= S_D1;
				S_D1: begin
					if ((scr_rd & bits) != 64'd0) flag_q <= 1'b1;
					cnt_q <= cnt_q + 12'd1;
					if ((5'(cnt_q[3:0]) + 5'd1 < 5'(nr)) &&
						(6'(vy_q[4:0]) + 6'(cnt_q[4:0]) + 6'd1 < 6'd32)) begin
						state_q <= S_D0;
					end else begin
						state_q <= S_WF;
					end
				end
				S_B1: state_q <= S_B2;
				S_B2: state_q <= S_OUT;
				S_S0: state_q <= S_S1;
				S_L0: state_q <= S_L1;
				S_S1, S_L1: begin
					cnt_q <= cnt_q + 12'd1;
					if (cnt_q[3:0] == xr) begin
						if (var_q == c8i_pkg::VAR_ORIG) i_q <= i_q + {12'd0, xr} + 16'd1;
						state_q <= S_OUT;
					end else begin
						state_q <= (state_q == S_S1) ? S_S0 : S_L0;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q <= (halt_q != c8i_pkg::ST_OK) ? halt_q :
							(wait_q ? c8i_pkg::ST_WAIT : c8i_pkg::ST_OK);
						pc_out_q <= pc_q;
						snd_q <= (st_q != 8'd0);
						row_out_q <= row_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign program_counter_out = pc_out_q;
	assign sound_active = snd_q;
	assign row_pixels = row_out_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sl_q <= 5'(STACK_DEPTH)) else $error("stack level beyond depth");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("result without sequencer");
	a_exec_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EX |-> halt_q == c8i_pkg::ST_OK) else $error("execute while halted");
	a_no_idle_vwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !vrf_we) else $error("register write while idle");

endmodule

FILE: verif/chip8_interpreter_core_test.sv
// Self-checking CHIP-8 interpreter core testbench: directed table, random programs, stack overflow.
`timescale 1ns / 1ps
module chip8_interpreter_core_test;
	import c8i_pkg::*;

	localparam int STK_DEPTH = 16;
	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;
	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP = 8'hA1;
	localparam logic [7:0] F_GET_DT = 8'h07;
	localparam logic [7:0] F_WAIT_KEY = 8'h0A;
	localparam logic [7:0] F_SET_DT = 8'h15;
	localparam logic [7:0] F_SET_ST = 8'h18;
	localparam logic [7:0] F_ADD_I = 8'h1E;
	localparam logic [7:0] F_GLYPH = 8'h29;
	localparam logic [7:0] F_BCD = 8'h33;
	localparam logic [7:0] F_STORE = 8'h55;
	localparam logic [7:0] F_FETCH = 8'h65;

	typedef struct {
		logic [1:0]  st;
		logic [11:0] pc;
		logic        snd;
		logic [63:0] row;
	} outcome_t;

	typedef struct {
		logic [2:0]  act;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [15:0] keys;
		logic [7:0]  rnd;
		logic [4:0]  rsel;
		bit          typed;
		outcome_t    want;
	} item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [11:0] load_address;
	logic [7:0]  load_data;
	logic [15:0] key_mask;
	logic [7:0]  random_byte;
	logic [4:0]  row_select;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [11:0] program_counter_out;
	logic        sound_active;
	logic [63:0] row_pixels;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  machine_variant;

	logic [7:0]  mem_img [4096];
	logic [63:0] scr [32];
	logic [7:0]  vr [16];
	logic [11:0] pc_r;
	logic [15:0] ireg;
	logic [11:0] ret_stk [16];
	int unsigned lvl;
	logic [7:0]  dly;
	logic [7:0]  snd;
	logic [15:0] keys_r;
	logic [15:0] watch;
	logic [1:0]  halt_code;
	logic [1:0]  variant;

	outcome_t pending_q[$];
	item_t    dir_tab[$];
	int       errors;
	int       src_idle;
	int       rcv_idle;
	int       hold_asks;
	int       hold_seen;
	int       hold_left;

	chip8_interpreter_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.load_address(load_address),
		.load_data(load_data),
		.key_mask(key_mask),
		.random_byte(random_byte),
		.row_select(row_select),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.program_counter_out(program_counter_out),
		.sound_active(sound_active),
		.row_pixels(row_pixels),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.machine_variant(machine_variant)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	function automatic logic [3:0] lowest_key(input logic [15:0] m);
		for (int k = 0; k < 16; k++)
			if (m[k]) return k[3:0];
		return 4'd0;
	endfunction

	function automatic void clear_model();
		for (int a = 0; a < 4096; a++) mem_img[a] = 8'h00;
		mem_img[0] = 8'h10;
		for (int a = 0; a < 80; a++) mem_img[FONT_BASE + a] = FONT[a];
		for (int r = 0; r < 32; r++) scr[r] = 64'd0;
		for (int r = 0; r < 16; r++) begin
			vr[r] = 8'd0;
			ret_stk[r] = 12'd0;
		end
		pc_r = 12'd0;
		ireg = 16'd0;
		lvl = 0;
		dly = 8'd0;
		snd = 8'd0;
		keys_r = 16'd0;
		watch = 16'd0;
		halt_code = ST_OK;
		variant = VAR_EXT;
	endfunction

	function automatic logic [15:0] opcode_at_pc();
		return {mem_img[pc_r], mem_img[pc_r + 12'd1]};
	endfunction

	function automatic bit would_halt();
		logic [15:0] op;
		op = opcode_at_pc();
		case (op[15:12])
			4'h0: return !(op == OP_CLS || (op == OP_RET && lvl != 0));
			4'h2: return lvl >= STK_DEPTH;
			4'h8: return !(op[3:0] <= 4'h7 || op[3:0] == 4'hE);
			4'hE: return !(op[7:0] == KEY_DOWN || op[7:0] == KEY_UP);
			4'hF: return !(op[7:0] inside {F_GET_DT, F_WAIT_KEY, F_SET_DT, F_SET_ST, F_ADD_I,
				F_GLYPH, F_BCD, F_STORE, F_FETCH});
			default: return 1'b0;
		endcase
	endfunction

	// returns 1 while the key wait has not completed
	function automatic bit run_op(input logic [7:0] rnd);
		logic [15:0] op;
		logic [3:0]  x, y, n;
		logic [7:0]  nn, t8;
		logic [11:0] nnn, a;
		logic [8:0]  sum;
		logic [15:0] up;
		logic [5:0]  cx;
		logic [4:0]  cy;
		logic [63:0] bits;
		logic        f;
		op = opcode_at_pc();
		x = op[11:8];
		y = op[7:4];
		n = op[3:0];
		nn = op[7:0];
		nnn = op[11:0];
		a = ireg[11:0];
		pc_r = pc_r + 12'd2;
		case (op[15:12])
			4'h0: begin
				if (nnn == OP_CLS[11:0]) begin
					for (int r = 0; r < 32; r++) scr[r] = 64'd0;
				end else if (nnn == OP_RET[11:0]) begin
					if (lvl == 0) halt_code = ST_STK;
					else begin
						lvl--;
						pc_r = ret_stk[lvl[3:0]];
					end
				end else halt_code = ST_BAD;
			end
			4'h1: pc_r = nnn;
			4'h2: begin
				if (lvl >= STK_DEPTH) halt_code = ST_STK;
				else begin
					ret_stk[lvl[3:0]] = pc_r;
					lvl++;
					pc_r = nnn;
				end
			end
			4'h3: if (vr[x] == nn) pc_r = pc_r + 12'd2;
			4'h4: if (vr[x] != nn) pc_r = pc_r + 12'd2;
			4'h5: if (vr[x] == vr[y]) pc_r = pc_r + 12'd2;
			4'h6: vr[x] = nn;
			4'h7: vr[x] = vr[x] + nn;
			4'h8: begin
				case (n)
					4'h0: vr[x] = vr[y];
					4'h1: begin
						vr[x] = vr[x] | vr[y];
						if (variant == VAR_ORIG) vr[15] = 8'd0;
					end
					4'h2: begin
						vr[x] = vr[x] & vr[y];
						if (variant == VAR_ORIG) vr[15] = 8'd0;
					end
					4'h3: begin
						vr[x] = vr[x] ^ vr[y];
						if (variant == VAR_ORIG) vr[15] = 8'd0;
					end
					4'h4: begin
						sum = {1'b0, vr[x]} + {1'b0, vr[y]};
						vr[x] = sum[7:0];
						vr[15] = {7'd0, sum[8]};
					end
					4'h5: begin
						f = vr[x] >= vr[y];
						vr[x] = vr[x] - vr[y];
						vr[15] = {7'd0, f};
					end
					4'h6: begin
						if (variant == VAR_ORIG) vr[x] = vr[y];
						f = vr[x][0];
						vr[x] = vr[x] >> 1;
						vr[15] = {7'd0, f};
					end
					4'h7: begin
						f = vr[y] >= vr[x];
						vr[x] = vr[y] - vr[x];
						vr[15] = {7'd0, f};
					end
					4'hE: begin
						if (variant == VAR_ORIG) vr[x] = vr[y];
						f = vr[x][7];
						vr[x] = vr[x] << 1;
						vr[15] = {7'd0, f};
					end
					default: halt_code = ST_BAD;
				endcase
			end
			4'h9: if (vr[x] != vr[y]) pc_r = pc_r + 12'd2;
			4'hA: ireg = {4'd0, nnn};
			4'hB: begin
				t8 = (variant == VAR_LATER || variant == VAR_EXT) ? vr[x] : vr[0];
				pc_r = nnn + {4'd0, t8};
			end
			4'hC: vr[x] = rnd & nn;
			4'hD: begin
				cx = vr[x][5:0];
				cy = vr[y][4:0];
				vr[15] = 8'd0;
				for (int r = 0; r < n && cy + r < 32; r++) begin
					bits = {mem_img[a + r[11:0]], 56'd0} >> cx;
					if ((scr[cy + r] & bits) != 64'd0) vr[15] = 8'd1;
					scr[cy + r] = scr[cy + r] ^ bits;
				end
			end
			4'hE: begin
				f = keys_r[vr[x][3:0]];
				if (nn == KEY_DOWN) begin
					if (f) pc_r = pc_r + 12'd2;
				end else if (nn == KEY_UP) begin
					if (!f) pc_r = pc_r + 12'd2;
				end else halt_code = ST_BAD;
			end
			default: begin
				case (nn)
					F_GET_DT: vr[x] = dly;
					F_WAIT_KEY: begin
						if (variant == VAR_ORIG) begin
							up = watch & ~keys_r;
							if (watch == 16'd0) watch = keys_r;
							else if (up != 16'd0) begin
								watch = 16'd0;
								vr[x] = {4'd0, lowest_key(up)};
								return 1'b0;
							end else watch = watch | keys_r;
						end else if (keys_r != 16'd0) begin
							vr[x] = {4'd0, lowest_key(keys_r)};
							return 1'b0;
						end
						pc_r = pc_r - 12'd2;
						return 1'b1;
					end
					F_SET_DT: dly = vr[x];
					F_SET_ST: snd = vr[x];
					F_ADD_I: begin
						t8 = vr[x];
						if (variant == VAR_ADDF)
							vr[15] = {7'd0, ireg < 16'h0FFF && {1'b0, ireg} + 17'(t8) >= 17'h1000};
						ireg = ireg + {8'd0, t8};
					end
					F_GLYPH: begin
						t8 = (variant == VAR_ORIG) ? {4'd0, vr[x][3:0]} : vr[x];
						ireg = {4'd0, FONT_BASE} + 16'(t8) * 16'd5;
					end
					F_BCD: begin
						t8 = vr[x];
						mem_img[a] = t8 / 8'd100;
						mem_img[a + 12'd1] = (t8 / 8'd10) % 8'd10;
						mem_img[a + 12'd2] = t8 % 8'd10;
					end
					F_STORE: begin
						for (int i = 0; i <= x; i++) mem_img[a + i[11:0]] = vr[i];
						if (variant == VAR_ORIG) ireg = ireg + {12'd0, x} + 16'd1;
					end
					F_FETCH: begin
						for (int i = 0; i <= x; i++) vr[i] = mem_img[a + i[11:0]];
						if (variant == VAR_ORIG) ireg = ireg + {12'd0, x} + 16'd1;
					end
					default: halt_code = ST_BAD;
				endcase
			end
		endcase
		return 1'b0;
	endfunction

	function automatic outcome_t core_outcome(input item_t s);
		outcome_t r;
		bit waiting;
		waiting = 1'b0;
		r.row = 64'd0;
		case (s.act)
			ACT_EXEC: if (halt_code == ST_OK) waiting = run_op(s.rnd);
			ACT_TICK: begin
				if (dly != 8'd0) dly--;
				if (snd != 8'd0) snd--;
			end
			ACT_LOAD: begin
				mem_img[s.addr] = s.data;
				pc_r = PROGRAM_BASE;
			end
			ACT_KEYS: keys_r = s.keys;
			ACT_ROW: r.row = scr[s.rsel];
			default: ;
		endcase
		r.st = (halt_code != ST_OK) ? halt_code : (waiting ? ST_WAIT : ST_OK);
		r.pc = pc_r;
		r.snd = snd != 8'd0;
		return r;
	endfunction

	function automatic item_t mk_item(input logic [2:0] act, input logic [11:0] addr,
		input logic [7:0] data, input logic [15:0] keys);
		item_t s;
		s.act = act;
		s.addr = addr;
		s.data = data;
		s.keys = keys;
		s.rnd = 8'($urandom);
		s.rsel = 5'($urandom);
		s.typed = 1'b0;
		s.want = '{ST_OK, 12'd0, 1'b0, 64'd0};
		return s;
	endfunction

	function automatic void add_row(input logic [2:0] act, input logic [11:0] addr,
		input logic [7:0] data, input logic [15:0] keys, input logic [4:0] rsel,
		input bit typed, input logic [1:0] st, input logic [11:0] pc);
		item_t s;
		s = mk_item(act, addr, data, keys);
		s.rsel = rsel;
		s.typed = typed;
		s.want = '{st, pc, 1'b0, 64'd0};
		dir_tab.push_back(s);
	endfunction

	task automatic send_item(input item_t s);
		outcome_t r;
		if (src_idle > 0 && $urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= s.act;
		load_address <= s.addr;
		load_data <= s.data;
		key_mask <= s.keys;
		random_byte <= s.rnd;
		row_select <= s.rsel;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = core_outcome(s);
		if (s.typed) r = s.want;
		pending_q.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_variant(input logic [1:0] v);
		cfg_valid <= 1'b1;
		machine_variant <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		variant = v;
	endtask

	function automatic logic [11:0] jump_target();
		if ($urandom_range(0, 7) == 0) return 12'($urandom);
		return PROGRAM_BASE + 12'(2 * $urandom_range(0, 23));
	endfunction

	function automatic logic [15:0] rand_op();
		logic [3:0] x, y, n;
		logic [7:0] nn;
		logic [3:0] alu [9];
		logic [7:0] fsub [9];
		alu = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
		fsub = '{F_GET_DT, F_WAIT_KEY, F_SET_DT, F_SET_ST, F_ADD_I, F_GLYPH, F_BCD, F_STORE,
			F_FETCH};
		x = 4'($urandom);
		y = 4'($urandom);
		n = 4'($urandom);
		case ($urandom_range(0, 3))
			0: nn = 8'h00;
			1: nn = 8'hFF;
			default: nn = 8'($urandom);
		endcase
		case ($urandom_range(0, 19))
			0: return OP_CLS;
			1: return OP_RET;
			2: return {4'h1, jump_target()};
			3: return {4'h2, jump_target()};
			4: return {4'h3, x, nn};
			5: return {4'h4, x, nn};
			6: return {4'h5, x, y, n};
			7: return {4'h6, x, nn};
			8: return {4'h7, x, nn};
			9, 10: return {4'h8, x, y, alu[$urandom_range(0, 8)]};
			11: return {4'h9, x, y, n};
			12: return {4'hA, 12'($urandom)};
			13: return {4'hB, PROGRAM_BASE + 12'(2 * $urandom_range(0, 16))};
			14: return {4'hC, x, nn};
			15, 16: return {4'hD, x, y, n};
			17: return {4'hE, x, $urandom_range(0, 1) ? KEY_DOWN : KEY_UP};
			default: return {4'hF, x, fsub[$urandom_range(0, 8)]};
		endcase
	endfunction

	task automatic send_op(input logic [11:0] addr, input logic [15:0] op);
		send_item(mk_item(ACT_LOAD, addr, op[15:8], 16'd0));
		send_item(mk_item(ACT_LOAD, addr + 12'd1, op[7:0], 16'd0));
	endtask

	task automatic random_item();
		int r;
		logic [15:0] k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 1) ? 16'($urandom) : 16'd1 << $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) k = 16'd0;
		if (r < 6) send_op(PROGRAM_BASE + 12'(2 * $urandom_range(0, 23)), rand_op());
		else if (r < 9) send_item(mk_item(ACT_LOAD, 12'($urandom), 8'($urandom), 16'd0));
		else if (r < 17) send_item(mk_item(ACT_KEYS, 12'd0, 8'd0, k));
		else if (r < 23) send_item(mk_item(ACT_TICK, 12'd0, 8'd0, 16'd0));
		else if (r < 29) send_item(mk_item(ACT_ROW, 12'd0, 8'd0, 16'd0));
		else if (r < 31) send_item(mk_item(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom),
			16'($urandom)));
		else if (would_halt())
			send_item(mk_item(ACT_LOAD, PROGRAM_BASE, 8'h60 | 8'($urandom_range(0, 15)), 16'd0));
		else send_item(mk_item(ACT_EXEC, 12'd0, 8'd0, 16'd0));
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) report("unexpected item", 64'd0, 64'd1);
			else begin
				w = pending_q.pop_front();
				if (status !== w.st) report("status", 64'(w.st), 64'(status));
				if (program_counter_out !== w.pc)
					report("program_counter_out", 64'(w.pc), 64'(program_counter_out));
				if (sound_active !== w.snd) report("sound_active", 64'(w.snd), 64'(sound_active));
				if (row_pixels !== w.row) report("row_pixels", w.row, row_pixels);
			end
		end
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else out_stall <= rcv_idle > 0 && $urandom_range(0, 99) < rcv_idle;
	end

	initial begin
		logic [1:0] phase_variant [6];
		phase_variant = '{VAR_ORIG, VAR_ADDF, VAR_LATER, VAR_EXT, VAR_ORIG, VAR_ADDF};
		errors = 0;
		src_idle = 0;
		rcv_idle = 0;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_EXEC;
		load_address = 12'd0;
		load_data = 8'd0;
		key_mask = 16'd0;
		random_byte = 8'd0;
		row_select = 5'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		machine_variant = VAR_EXT;
		clear_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		add_row(ACT_ROW, 12'd0, 8'd0, 16'd0, 5'd31, 1, ST_OK, 12'd0);
		add_row(ACT_EXEC, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'd0);
		add_row(ACT_KEYS, 12'd0, 8'd0, 16'hFFFF, 5'd0, 1, ST_OK, 12'd0);
		add_row(ACT_KEYS, 12'd0, 8'd0, 16'h0000, 5'd0, 1, ST_OK, 12'd0);
		add_row(3'd5, 12'hFFF, 8'hFF, 16'hFFFF, 5'd31, 1, ST_OK, 12'd0);
		add_row(3'd7, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'd0);
		add_row(ACT_TICK, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'd0);
		add_row(ACT_LOAD, 12'hFFF, 8'hFF, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h200, 8'h60, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h201, 8'hFF, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h202, 8'hA0, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h203, 8'h50, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h204, 8'hD0, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h205, 8'h15, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h206, 8'hF1, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_LOAD, 12'h207, 8'h0A, 16'd0, 5'd0, 1, ST_OK, PROGRAM_BASE);
		add_row(ACT_EXEC, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'h202);
		add_row(ACT_EXEC, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'h204);
		add_row(ACT_EXEC, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'h206);
		add_row(ACT_ROW, 12'd0, 8'd0, 16'd0, 5'd0, 0, ST_OK, 12'd0);
		add_row(ACT_EXEC, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_WAIT, 12'h206);
		add_row(ACT_KEYS, 12'd0, 8'd0, 16'h8000, 5'd0, 1, ST_OK, 12'h206);
		add_row(ACT_EXEC, 12'd0, 8'd0, 16'd0, 5'd0, 1, ST_OK, 12'h208);
		foreach (dir_tab[i]) send_item(dir_tab[i]);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					src_idle = 10;
					rcv_idle = 50;
				end
				1: begin
					src_idle = 50;
					rcv_idle = 10;
				end
				default: begin
					src_idle = 0;
					rcv_idle = 0;
				end
			endcase
			write_variant(phase_variant[p]);
			if (p == 1) hold_asks++;
			for (int k = 0; k < 24; k++) send_op(PROGRAM_BASE + 12'(2 * k), rand_op());
			for (int j = 0; j < 130; j++) random_item();
			drain();
		end

		// call into itself until the return stack overflows, then poke the halted core
		send_op(PROGRAM_BASE, {4'h2, PROGRAM_BASE});
		for (int j = 0; j < 20 && halt_code == ST_OK; j++)
			send_item(mk_item(ACT_EXEC, 12'd0, 8'd0, 16'd0));
		send_item(mk_item(ACT_EXEC, 12'd0, 8'd0, 16'd0));
		send_item(mk_item(ACT_ROW, 12'd0, 8'd0, 16'd0));
		send_item(mk_item(ACT_TICK, 12'd0, 8'd0, 16'd0));
		send_item(mk_item(ACT_KEYS, 12'd0, 8'd0, 16'h0001));
		drain();
		repeat (64) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
sv/c8i_pkg.sv
sv/c8i_ram.sv
sv/chip8_interpreter_core.sv
verif/chip8_interpreter_core_test.sv
